>>> rtl/rate_monotonic_tick_scheduler_assert.svh
// assertion macros for the tick scheduler
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
// implication checked on every clock, off during reset
`define RMTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RMTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/rmts_pkg.sv
// shared types and constants for the tick scheduler
package rmts_pkg;
	localparam int NumRegs = 8;
	localparam logic [2:0] KIND_IDLE = 3'd0;
	localparam logic [2:0] KIND_HOLD = 3'd1;
	localparam logic [2:0] KIND_LOST = 3'd2;
	localparam logic [2:0] KIND_FINISHED = 3'd3;
	localparam logic [2:0] KIND_KILLED = 3'd4;
	localparam logic [2:0] KIND_REPORT = 3'd5;

	// one emitted result
	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  task_index;
		logic [31:0] run_length;
		logic [15:0] lost_total;
		logic [15:0] completed_total;
		logic        was_killed;
		logic        last_of_tick;
	} result_t;

	// queued tick
	typedef struct packed {
		logic final_tick;
	} tick_t;
endpackage

>>> rtl/rmts_tick_fifo.sv
// two-entry queue between tick intake and the scheduling engine
module rmts_tick_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rmts_pkg::tick_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rmts_pkg::tick_t    out_data
);
	rmts_pkg::tick_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`include "rate_monotonic_tick_scheduler_assert.svh"
	`RMTS_ASSERT_IMP(a_no_overflow, clk, arst_n, cnt_q == 2'd2, !push, "queue overflow")
	`RMTS_ASSERT_NXT(a_cnt_track, clk, arst_n, push && !pop && cnt_q == 2'd0, cnt_q == 2'd1, "count slip")
	`RMTS_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "count out of range")
endmodule

>>> rtl/rmts_engine.sv
// scheduling engine: release, select, run and emit events per tick, and per-task reports on a final tick
module rmts_engine #(
	parameter int MAX_TASKS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           task_word [rmts_pkg::NumRegs],
	input  logic                  tick_valid,
	output logic                  tick_ready,
	input  rmts_pkg::tick_t       tick_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output rmts_pkg::result_t     res_data
);
	localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_RELEASE = 7'b0000010,
		ST_SELECT  = 7'b0000100,
		ST_RUN     = 7'b0001000,
		ST_EMIT    = 7'b0010000,
		ST_REPORT  = 7'b0100000,
		ST_WRAP    = 7'b1000000
	} state_t;

	state_t      state_q;
	logic        fin_q;
	logic [TW-1:0] idx_q;
	logic        started_q;
	logic [31:0] tick_number_q;
	logic [31:0] next_release_q [MAX_TASKS];
	logic [15:0] remaining_q [MAX_TASKS];
	logic [15:0] lost_q [MAX_TASKS];
	logic [15:0] completed_q [MAX_TASKS];
	logic [2:0]  prev_task_q;
	logic        prev_valid_q;
	logic [15:0] prev_rem_q;
	logic [31:0] run_q;
	logic [31:0] idle_q;
	logic        best_valid_q;
	logic [TW-1:0] best_q;
	logic [15:0] best_period_q;
	// pending events of this tick: idle, hold/lost, finished/killed
	rmts_pkg::result_t ev_q [3];
	logic [2:0]  ev_pend_q;
	logic        res_valid_q;
	rmts_pkg::result_t res_q;

	logic [15:0] period_i;
	logic [15:0] budget_i;
	logic [31:0] nr_cur;
	logic [15:0] rem_cur;
	logic [32:0] rel_sum;
	logic        idx_last;
	logic [2:0]  best3;
	logic [15:0] rem_after;
	logic        hold_c;
	logic        lost_c;
	logic [31:0] run_mid;
	logic [31:0] run_inc;
	logic [31:0] idle_inc;
	logic        out_free;
	logic        res_load;
	logic [1:0]  ev_sel;
	logic        ev_more;
	rmts_pkg::result_t ev_out;
	rmts_pkg::result_t ev0_n;
	rmts_pkg::result_t ev1_n;
	rmts_pkg::result_t ev2_n;

	assign period_i = task_word[idx_q][31:16];
	assign budget_i = task_word[idx_q][15:0];
	// first tick of a run loads release time and budget before the release check
	assign nr_cur   = started_q ? next_release_q[idx_q] : {16'd0, period_i};
	assign rem_cur  = started_q ? remaining_q[idx_q] : budget_i;
	assign rel_sum  = {1'b0, nr_cur} + {17'd0, period_i};
	assign idx_last = (idx_q == TW'(MAX_TASKS - 1));
	assign best3    = 3'(best_q);
	assign rem_after = remaining_q[best_q] - 16'd1;
	assign hold_c   = prev_valid_q && (prev_task_q != best3) && (prev_rem_q != 16'd0);
	assign lost_c   = prev_valid_q && (prev_task_q == best3) && (prev_rem_q < rem_after)
		&& (run_q != 32'd0);
	assign run_mid  = (hold_c || lost_c) ? 32'd0 : run_q;
	assign run_inc  = (run_mid == 32'hFFFF_FFFF) ? run_mid : run_mid + 32'd1;
	assign idle_inc = (idle_q == 32'hFFFF_FFFF) ? idle_q : idle_q + 32'd1;
	assign out_free = !res_valid_q || res_ready;
	assign res_load = out_free && ((state_q == ST_EMIT && ev_pend_q != 3'd0)
		|| state_q == ST_REPORT);
	assign tick_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;

	always_comb begin
		ev_sel = 2'd0;
		if (ev_pend_q[0]) begin
			ev_sel = 2'd0;
		end else if (ev_pend_q[1]) begin
			ev_sel = 2'd1;
		end else begin
			ev_sel = 2'd2;
		end
		case (ev_sel)
			2'd0: ev_more = |ev_pend_q[2:1];
			2'd1: ev_more = ev_pend_q[2];
			default: ev_more = 1'b0;
		endcase
		ev_out = ev_q[ev_sel];
		ev_out.last_of_tick = !ev_more && !fin_q;
	end

	always_comb begin
		ev0_n = '0;
		ev1_n = '0;
		ev2_n = '0;
		ev0_n.event_kind = rmts_pkg::KIND_IDLE;
		if (best_valid_q) begin
			ev0_n.run_length = idle_q;
			ev1_n.event_kind = hold_c ? rmts_pkg::KIND_HOLD : rmts_pkg::KIND_LOST;
			ev1_n.task_index = hold_c ? prev_task_q : best3;
			ev1_n.run_length = run_q;
			ev2_n.event_kind = (rem_after == 16'd0) ? rmts_pkg::KIND_FINISHED
				: rmts_pkg::KIND_KILLED;
			ev2_n.task_index = best3;
			ev2_n.run_length = run_inc;
		end else begin
			ev0_n.run_length = idle_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT && ev_pend_q != 3'd0) begin
			res_q <= ev_out;
		end else if (out_free && state_q == ST_REPORT) begin
			res_q.event_kind      <= rmts_pkg::KIND_REPORT;
			res_q.task_index      <= 3'(idx_q);
			res_q.run_length      <= 32'd0;
			res_q.lost_total      <= lost_q[idx_q];
			res_q.completed_total <= completed_q[idx_q];
			res_q.was_killed      <= (remaining_q[idx_q] != 16'd0);
			res_q.last_of_tick    <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fin_q         <= 1'b0;
			idx_q         <= '0;
			started_q     <= 1'b0;
			tick_number_q <= 32'd0;
			prev_task_q   <= 3'd0;
			prev_valid_q  <= 1'b0;
			prev_rem_q    <= 16'd0;
			run_q         <= 32'd0;
			idle_q        <= 32'd0;
			best_valid_q  <= 1'b0;
			best_q        <= '0;
			best_period_q <= 16'd0;
			ev_pend_q     <= 3'd0;
			res_valid_q   <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				next_release_q[i] <= 32'd0;
				remaining_q[i]    <= 16'd0;
				lost_q[i]         <= 16'd0;
				completed_q[i]    <= 16'd0;
			end
			for (int k = 0; k < 3; k++) begin
				ev_q[k] <= '0;
			end
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						fin_q        <= tick_data.final_tick;
						idx_q        <= '0;
						best_valid_q <= 1'b0;
						ev_pend_q    <= 3'd0;
						state_q      <= ST_RELEASE;
					end
				end
				ST_RELEASE: begin
					if (nr_cur <= tick_number_q) begin
						if (rem_cur != 16'd0 && lost_q[idx_q] != 16'hFFFF) begin
							lost_q[idx_q] <= lost_q[idx_q] + 16'd1;
						end
						next_release_q[idx_q] <= rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
						remaining_q[idx_q]    <= budget_i;
					end else if (!started_q) begin
						next_release_q[idx_q] <= nr_cur;
						remaining_q[idx_q]    <= rem_cur;
					end
					if (idx_last) begin
						started_q <= 1'b1;
						idx_q     <= '0;
						state_q   <= ST_SELECT;
					end else begin
						idx_q <= idx_q + TW'(1);
					end
				end
				ST_SELECT: begin
					if (remaining_q[idx_q] != 16'd0
						&& (!best_valid_q || period_i < best_period_q)) begin
						best_valid_q  <= 1'b1;
						best_q        <= idx_q;
						best_period_q <= period_i;
					end
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_RUN;
					end else begin
						idx_q <= idx_q + TW'(1);
					end
				end
				ST_RUN: begin
					ev_q[0] <= ev0_n;
					ev_q[1] <= ev1_n;
					ev_q[2] <= ev2_n;
					if (best_valid_q) begin
						ev_pend_q <= {(rem_after == 16'd0) || fin_q, hold_c || lost_c,
							idle_q != 32'd0};
						remaining_q[best_q] <= rem_after;
						if (rem_after == 16'd0) begin
							if (completed_q[best_q] != 16'hFFFF) begin
								completed_q[best_q] <= completed_q[best_q] + 16'd1;
							end
							run_q <= 32'd0;
						end else if (fin_q) begin
							run_q <= 32'd0;
						end else begin
							run_q <= run_inc;
						end
						prev_task_q  <= best3;
						prev_rem_q   <= rem_after;
						prev_valid_q <= 1'b1;
						idle_q       <= 32'd0;
					end else begin
						idle_q    <= idle_inc;
						ev_pend_q <= {2'b00, fin_q};
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (ev_pend_q == 3'd0) begin
						state_q <= fin_q ? ST_REPORT : ST_WRAP;
					end else if (out_free) begin
						ev_pend_q[ev_sel] <= 1'b0;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						if (idx_last) begin
							state_q <= ST_WRAP;
						end else begin
							idx_q <= idx_q + TW'(1);
						end
					end
				end
				ST_WRAP: begin
					if (fin_q) begin
						tick_number_q <= 32'd0;
						started_q     <= 1'b0;
						prev_task_q   <= 3'd0;
						prev_valid_q  <= 1'b0;
						prev_rem_q    <= 16'd0;
						run_q         <= 32'd0;
						idle_q        <= 32'd0;
						for (int i = 0; i < MAX_TASKS; i++) begin
							next_release_q[i] <= 32'd0;
							remaining_q[i]    <= 16'd0;
							lost_q[i]         <= 16'd0;
							completed_q[i]    <= 16'd0;
						end
					end else if (tick_number_q != 32'hFFFF_FFFF) begin
						tick_number_q <= tick_number_q + 32'd1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "rate_monotonic_tick_scheduler_assert.svh"
	`RMTS_ASSERT_IMP(a_hold_lost_excl, clk, arst_n, state_q == ST_RUN && best_valid_q, !(hold_c && lost_c), "hold and lost together")
	`RMTS_ASSERT_IMP(a_res_hold, clk, arst_n, res_valid_q && !res_ready && state_q != ST_IDLE, !out_free, "output overwrite")
	`RMTS_ASSERT_NXT(a_wrap_clear, clk, arst_n, state_q == ST_WRAP && fin_q, !started_q && tick_number_q == 32'd0, "run not cleared")
endmodule

>>> rtl/rate_monotonic_tick_scheduler.sv
// Tick scheduler: each accepted tick is queued (two deep) and processed by the
// engine in order: the accepting cycle, a release pass and a selection pass over
// the tasks, the run step, the emitted events, a closing emit step, the reports
// on a final tick and the wrap step; up to 3 events per tick and MAX_TASKS reports
// on the final tick. The engine takes the next tick only after the wrap; the single
// output register holds a result until taken. Task words sit at byte address 4*i over the APB port.
module rate_monotonic_tick_scheduler #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        final_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [2:0]  task_index,
	output logic [31:0] run_length,
	output logic [15:0] lost_total,
	output logic [15:0] completed_total,
	output logic        was_killed,
	output logic        last_of_tick
);
	logic [31:0] task_word_q [rmts_pkg::NumRegs];
	rmts_pkg::tick_t   in_tick;
	rmts_pkg::tick_t   q_tick;
	logic              q_valid;
	logic              q_ready;
	rmts_pkg::result_t res;

	assign pready  = 1'b1;
	assign prdata  = task_word_q[paddr[4:2]];
	assign in_tick.final_tick = final_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rmts_pkg::NumRegs; i++) begin
				task_word_q[i] <= 32'd0;
			end
		end else if (psel && penable && pwrite) begin
			task_word_q[paddr[4:2]] <= pwdata;
		end
	end

	rmts_tick_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_tick),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_tick)
	);

	rmts_engine #(
		.MAX_TASKS (MAX_TASKS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_word  (task_word_q),
		.tick_valid (q_valid),
		.tick_ready (q_ready),
		.tick_data  (q_tick),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res_data   (res)
	);

	assign event_kind      = res.event_kind;
	assign task_index      = res.task_index;
	assign run_length      = res.run_length;
	assign lost_total      = res.lost_total;
	assign completed_total = res.completed_total;
	assign was_killed      = res.was_killed;
	assign last_of_tick    = res.last_of_tick;
endmodule

>>> tb/rate_monotonic_tick_scheduler_tb.sv
// testbench for the tick scheduler: random and directed ticks checked against a scheduling predictor
module rate_monotonic_tick_scheduler_tb;

	class tick_scoreboard;
		logic [31:0] task_word [8];
		logic [31:0] tick_number;
		logic [31:0] next_release [8];
		logic [15:0] remaining_budget [8];
		logic [15:0] lost_counts [8];
		logic [15:0] completed_counts [8];
		logic [2:0]  previous_task;
		bit          previous_valid;
		logic [15:0] previous_remaining;
		logic [31:0] run_counter;
		logic [31:0] idle_counter;
		bit          started;
		rmts_pkg::result_t expected_results [$];
		int          mismatches;
		int          results_seen;
		int          reports_seen;

		function void clear_run();
			tick_number = 0;
			foreach (next_release[i]) begin
				next_release[i] = 0;
				remaining_budget[i] = 0;
				lost_counts[i] = 0;
				completed_counts[i] = 0;
			end
			previous_task = 0;
			previous_valid = 0;
			previous_remaining = 0;
			run_counter = 0;
			idle_counter = 0;
			started = 0;
		endfunction

		function void reset_all();
			foreach (task_word[i]) task_word[i] = 0;
			clear_run();
			expected_results.delete();
			mismatches = 0;
			results_seen = 0;
			reports_seen = 0;
		endfunction

		function void push(logic [2:0] kind, logic [2:0] idx, logic [31:0] len,
				logic [15:0] lost, logic [15:0] comp, logic killed);
			rmts_pkg::result_t r;
			r.event_kind = kind;
			r.task_index = idx;
			r.run_length = len;
			r.lost_total = lost;
			r.completed_total = comp;
			r.was_killed = killed;
			r.last_of_tick = 0;
			expected_results.push_back(r);
		endfunction

		function logic [31:0] sat32(logic [31:0] v);
			return (v == 32'hFFFF_FFFF) ? v : v + 1;
		endfunction

		function logic [15:0] sat16(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 1;
		endfunction

		function void note_tick(logic fin);
			int best;
			int base;
			logic [31:0] p;
			best = -1;
			base = expected_results.size();
			if (!started) begin
				for (int i = 0; i < 8; i++) begin
					next_release[i] = {16'h0, task_word[i][31:16]};
					remaining_budget[i] = task_word[i][15:0];
				end
				started = 1;
			end
			for (int i = 0; i < 8; i++) begin
				if (next_release[i] <= tick_number) begin
					p = {16'h0, task_word[i][31:16]};
					if (remaining_budget[i] > 0) lost_counts[i] = sat16(lost_counts[i]);
					next_release[i] = (next_release[i] > 32'hFFFF_FFFF - p) ?
						32'hFFFF_FFFF : next_release[i] + p;
					remaining_budget[i] = task_word[i][15:0];
				end
			end
			for (int i = 0; i < 8; i++) begin
				if (remaining_budget[i] > 0 && (best < 0 ||
						task_word[i][31:16] < task_word[best][31:16]))
					best = i;
			end
			if (best >= 0) begin
				if (idle_counter > 0) push(rmts_pkg::KIND_IDLE, 0, idle_counter, 0, 0, 0);
				remaining_budget[best]--;
				if (previous_valid && previous_task != best && previous_remaining > 0) begin
					push(rmts_pkg::KIND_HOLD, previous_task, run_counter, 0, 0, 0);
					run_counter = 0;
				end
				if (previous_valid && previous_task == best &&
						previous_remaining < remaining_budget[best] && run_counter > 0) begin
					push(rmts_pkg::KIND_LOST, best, run_counter, 0, 0, 0);
					run_counter = 0;
				end
				run_counter = sat32(run_counter);
				if (remaining_budget[best] == 0) begin
					push(rmts_pkg::KIND_FINISHED, best, run_counter, 0, 0, 0);
					completed_counts[best] = sat16(completed_counts[best]);
					run_counter = 0;
				end else if (fin) begin
					push(rmts_pkg::KIND_KILLED, best, run_counter, 0, 0, 0);
					run_counter = 0;
				end
				previous_task = best;
				previous_remaining = remaining_budget[best];
				previous_valid = 1;
				idle_counter = 0;
			end else begin
				idle_counter = sat32(idle_counter);
				if (fin) push(rmts_pkg::KIND_IDLE, 0, idle_counter, 0, 0, 0);
			end
			if (fin) begin
				for (int i = 0; i < 8; i++)
					push(rmts_pkg::KIND_REPORT, i, 0, lost_counts[i], completed_counts[i],
						remaining_budget[i] > 0);
				clear_run();
			end else begin
				tick_number = sat32(tick_number);
			end
			if (expected_results.size() > base)
				expected_results[expected_results.size() - 1].last_of_tick = 1;
		endfunction

		function void check_result(rmts_pkg::result_t got);
			rmts_pkg::result_t exp;
			results_seen++;
			if (got.event_kind == rmts_pkg::KIND_REPORT) reports_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			exp = expected_results.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic        final_tick;
	logic        out_valid;
	logic        out_ready;
	rmts_pkg::result_t got;
	bit          calm;
	bit          timed_out;
	int          idle_cycles;
	tick_scoreboard sb;

	rate_monotonic_tick_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .final_tick(final_tick),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(got.event_kind), .task_index(got.task_index),
		.run_length(got.run_length), .lost_total(got.lost_total),
		.completed_total(got.completed_total), .was_killed(got.was_killed),
		.last_of_tick(got.last_of_tick)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(got);
			out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_task_word(int idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.task_word[idx] = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays high into the next transaction when no idle cycle is drawn
	task automatic send_tick(logic fin);
		while (!calm && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		final_tick <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_tick(fin);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() > 0 && !timed_out) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// random task set; small periods and budgets keep runs eventful
	task automatic load_random_set(bit extremes);
		logic [31:0] w;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 5))
				0: w = 0;
				1: w = {16'($urandom_range(0, 3)), 16'($urandom_range(1, 3))};
				2: w = extremes ? $urandom : {16'($urandom_range(0, 40)), 16'($urandom_range(0, 8))};
				default: w = {16'($urandom_range(1, 30)), 16'($urandom_range(1, 6))};
			endcase
			write_task_word(i, w);
		end
	endtask

	task automatic run_segment(int ticks);
		for (int t = 0; t < ticks; t++) send_tick(t == ticks - 1 || $urandom_range(0, 39) == 0);
	endtask

	initial begin
		timed_out = 0;
		forever begin
			@(posedge clk);
			if (idle_cycles > 5000) begin
				timed_out = 1;
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		sb.reset_all();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		final_tick = 1'b0;
		out_ready = 1'b0;
		calm = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no tasks, then extremes, ties, zero period, overruns
		send_tick(1'b0);
		send_tick(1'b1);
		drain();
		write_task_word(0, 32'hFFFF_FFFF);
		write_task_word(1, 32'h0000_0002);
		write_task_word(2, 32'h0003_0002);
		write_task_word(3, 32'h0003_0001);
		write_task_word(4, 32'h0005_0004);
		write_task_word(5, 32'hFFFF_0000);
		write_task_word(6, 32'h0002_0003);
		write_task_word(7, 32'h0000_0000);
		for (int t = 0; t < 10; t++) send_tick(1'b0);
		send_tick(1'b1);
		drain();
		write_task_word(1, 32'h0000_0000);
		write_task_word(6, 32'h0000_0000);
		for (int t = 0; t < 6; t++) send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			calm = (phase == 4);
			load_random_set(phase % 3 == 2);
			run_segment(27);
			drain();
		end
		write_task_word(0, 32'h0001_FFFF);
		write_task_word(5, 32'h0000_0000);
		run_segment(10);
		drain();

		$display("covered %0d results, %0d per-task reports, over directed and random task sets",
			sb.results_seen, sb.reports_seen);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.mismatches,
				sb.expected_results.size());
			$display("tb: failure");
		end
		$finish;
	end
endmodule
